>>> rtl/svf_pkg.sv
package svf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STATE_BITS  = 32;
  localparam int OVERSAMPLE  = 2;

  localparam int FREQ_FRAC = 18;
  localparam int DAMP_FRAC = 16;

  localparam int MODE_W = 3;
  localparam int FREQ_W = 17;
  localparam int DAMP_W = 18;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  localparam int COEF_W  = 18;
  localparam int DIGIT_W = 3;
  localparam int NDIG    = COEF_W / DIGIT_W;
  localparam int CNT_W   = $clog2(NDIG + 1);

  localparam int PROD_W = STATE_BITS + COEF_W;
  localparam int RMAG_W = PROD_W - DAMP_FRAC + 1;
  localparam int RES_W  = RMAG_W + 1;
  localparam int SUM_W  = RES_W + 1;
  localparam int SEL_W  = STATE_BITS + 1;

  localparam int PASS_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  localparam logic [MODE_W-1:0] MODE_LOW    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_HIGH   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_BAND   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_REJECT = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_BOOST  = MODE_W'(4);

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQ = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_DAMP = CFG_INDEX_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_ISSUE,
    ST_D_WAIT,
    ST_L_ISSUE,
    ST_L_WAIT,
    ST_B_ISSUE,
    ST_B_WAIT,
    ST_C_OUT,
    ST_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FREQ_W-1:0] freq;
    logic [DAMP_W-1:0] damp;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic damp_sel;
  } mul_req_t;

  typedef struct packed {
    logic idle;
    logic result_valid;
  } seq_stat_t;

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-STATE_BITS:0] upper;
    upper = v[SUM_W-1:STATE_BITS-1];
    if (upper == '0 || upper == '1) begin
      return v[STATE_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SEL_W-1:0] v
  );
    logic [SEL_W-SAMPLE_BITS:0] upper;
    upper = v[SEL_W-1:SAMPLE_BITS-1];
    if (upper == '0 || upper == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SEL_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/svf_mul.sv
module svf_mul import svf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  mul_req_t                     req,
  input  logic signed [STATE_BITS-1:0] operand,
  input  logic        [COEF_W-1:0]     coef,
  output logic                         done,
  output logic signed [RES_W-1:0]      product
);

  logic                          busy;
  logic [CNT_W-1:0]              count;
  logic                          neg;
  logic                          damp_sel;
  logic [STATE_BITS-1:0]         mag;
  logic [COEF_W-1:0]             coef_sr;
  logic [STATE_BITS-1:0]         acc;
  logic [COEF_W-1:0]             low_sr;

  logic [STATE_BITS-1:0]         op_u;
  logic [STATE_BITS-1:0]         op_abs;
  logic [STATE_BITS+DIGIT_W-1:0] partial;
  logic [STATE_BITS+DIGIT_W-1:0] sum;
  logic [PROD_W-1:0]             pfull;
  logic [RMAG_W-1:0]             rmag;

  assign op_u    = operand;
  assign op_abs  = op_u[STATE_BITS-1] ? (~op_u + STATE_BITS'(1)) : op_u;
  assign partial = {{DIGIT_W{1'b0}}, mag} *
                   {{STATE_BITS{1'b0}}, coef_sr[DIGIT_W-1:0]};
  assign sum     = {{DIGIT_W{1'b0}}, acc} + partial;
  assign pfull   = {acc, low_sr};

  always_comb begin
    if (damp_sel) begin
      rmag = {1'b0, pfull[PROD_W-1:DAMP_FRAC]} + RMAG_W'(pfull[DAMP_FRAC-1]);
    end else begin
      rmag = RMAG_W'(pfull[PROD_W-1:FREQ_FRAC]) + RMAG_W'(pfull[FREQ_FRAC-1]);
    end
  end

  assign product = neg ? (RES_W'(0) - {1'b0, rmag}) : {1'b0, rmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NDIG);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg      <= op_u[STATE_BITS-1];
      mag      <= op_abs;
      coef_sr  <= coef;
      acc      <= '0;
      low_sr   <= '0;
      damp_sel <= req.damp_sel;
    end else if (busy) begin
      low_sr  <= {sum[DIGIT_W-1:0], low_sr[COEF_W-1:DIGIT_W]};
      acc     <= sum[STATE_BITS+DIGIT_W-1:DIGIT_W];
      coef_sr <= coef_sr >> DIGIT_W;
    end
  end

endmodule

>>> rtl/svf_seq.sv
module svf_seq import svf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          clear_in,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  cfg_t                          cfg,
  input  logic                          result_take,
  output seq_stat_t                     stat,
  output logic signed [SAMPLE_BITS-1:0] left_res,
  output logic signed [SAMPLE_BITS-1:0] right_res,
  output mul_req_t                      mul_req,
  output logic signed [STATE_BITS-1:0]  mul_operand,
  output logic        [COEF_W-1:0]      mul_coef,
  input  logic                          mul_done,
  input  logic signed [RES_W-1:0]       mul_product
);

  seq_state_t state, state_next;

  logic                          chan;
  logic [PASS_W-1:0]             pass;
  logic signed [SAMPLE_BITS-1:0] x_l;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [STATE_BITS-1:0]  low  [2];
  logic signed [STATE_BITS-1:0]  band [2];
  logic signed [STATE_BITS-1:0]  notch;
  logic signed [STATE_BITS-1:0]  hp;

  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [STATE_BITS-1:0]  low_cur;
  logic signed [STATE_BITS-1:0]  band_cur;
  logic signed [STATE_BITS-1:0]  notch_new;
  logic signed [STATE_BITS-1:0]  low_new;
  logic signed [STATE_BITS-1:0]  hp_new;
  logic signed [STATE_BITS-1:0]  band_new;
  logic signed [SEL_W-1:0]       sel_v;
  logic signed [SAMPLE_BITS-1:0] out_res;
  logic                          last_pass;

  assign x_cur     = chan ? x_r : x_l;
  assign low_cur   = low[chan];
  assign band_cur  = band[chan];
  assign last_pass = (pass == PASS_W'(OVERSAMPLE - 1));

  assign notch_new = sat_state(SUM_W'(x_cur) - SUM_W'(mul_product));
  assign low_new   = sat_state(SUM_W'(low_cur) + SUM_W'(mul_product));
  assign hp_new    = sat_state(SUM_W'(notch) - SUM_W'(low_cur));
  assign band_new  = sat_state(SUM_W'(band_cur) + SUM_W'(mul_product));

  always_comb begin
    unique case (cfg.mode)
      MODE_HIGH:   sel_v = SEL_W'(hp);
      MODE_BAND:   sel_v = SEL_W'(band_cur);
      MODE_REJECT: sel_v = SEL_W'(notch);
      MODE_BOOST:  sel_v = SEL_W'(low_cur) - SEL_W'(hp);
      default:     sel_v = SEL_W'(low_cur);
    endcase
  end

  assign out_res = sat_sample(sel_v >>> 1);

  assign stat.idle         = (state == ST_IDLE);
  assign stat.result_valid = (state == ST_RESULT);

  always_comb begin
    state_next       = state;
    mul_req.start    = 1'b0;
    mul_req.damp_sel = 1'b0;
    mul_operand      = band_cur;
    mul_coef         = COEF_W'(cfg.freq);
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_D_ISSUE;
      end
      ST_D_ISSUE: begin
        mul_req.start    = 1'b1;
        mul_req.damp_sel = 1'b1;
        mul_coef         = COEF_W'(cfg.damp);
        state_next       = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (mul_done) state_next = ST_L_ISSUE;
      end
      ST_L_ISSUE: begin
        mul_req.start = 1'b1;
        state_next    = ST_L_WAIT;
      end
      ST_L_WAIT: begin
        if (mul_done) state_next = ST_B_ISSUE;
      end
      ST_B_ISSUE: begin
        mul_req.start = 1'b1;
        mul_operand   = hp_new;
        state_next    = ST_B_WAIT;
      end
      ST_B_WAIT: begin
        if (mul_done) state_next = last_pass ? ST_C_OUT : ST_D_ISSUE;
      end
      ST_C_OUT: begin
        state_next = chan ? ST_RESULT : ST_D_ISSUE;
      end
      ST_RESULT: begin
        if (result_take) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chan    <= 1'b0;
      pass    <= '0;
      low[0]  <= '0;
      low[1]  <= '0;
      band[0] <= '0;
      band[1] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            chan <= 1'b0;
            pass <= '0;
            x_l  <= left_in;
            x_r  <= right_in;
            if (clear_in) begin
              low[0]  <= '0;
              low[1]  <= '0;
              band[0] <= '0;
              band[1] <= '0;
            end
          end
        end
        ST_D_WAIT: begin
          if (mul_done) notch <= notch_new;
        end
        ST_L_WAIT: begin
          if (mul_done) low[chan] <= low_new;
        end
        ST_B_ISSUE: begin
          hp <= hp_new;
        end
        ST_B_WAIT: begin
          if (mul_done) begin
            band[chan] <= band_new;
            pass       <= last_pass ? '0 : pass + PASS_W'(1);
          end
        end
        ST_C_OUT: begin
          if (chan) begin
            right_res <= out_res;
          end else begin
            left_res <= out_res;
            chan     <= 1'b1;
          end
        end
        ST_D_ISSUE, ST_L_ISSUE, ST_RESULT: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/stereo_state_variable_filter_top.sv
// Stereo Chamberlin state-variable filter, run twice per sample. Each request
// carries a left and a right Q1.23 sample and returns half of the lowpass,
// highpass, bandpass, notch or peak signal of each channel. Every product goes
// through one shared multiplier that takes the coefficient three bits a cycle;
// a request runs three multiplies per pass, two passes and two channels, and
// its finished result then moves into the output register. One request is in
// flight at a time; the next is accepted while the previous result waits in
// the output register. Write the mode and coefficients only while no request
// is in progress.
module stereo_state_variable_filter_top import svf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          clear_state,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  input  logic                          cfg_write,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                          cfg;
  seq_stat_t                     stat;
  mul_req_t                      mul_req;
  logic signed [STATE_BITS-1:0]  mul_operand;
  logic        [COEF_W-1:0]      mul_coef;
  logic                          mul_done;
  logic signed [RES_W-1:0]       mul_product;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;
  logic                          result_take;

  assign in_ready    = stat.idle;
  assign result_take = stat.result_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_BAND;
      cfg.freq <= '0;
      cfg.damp <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE: cfg.mode <= cfg_data[MODE_W-1:0];
        CFG_FREQ: cfg.freq <= cfg_data[FREQ_W-1:0];
        CFG_DAMP: cfg.damp <= cfg_data[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      left_out  <= left_res;
      right_out <= right_res;
    end
  end

  svf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .operand (mul_operand),
    .coef    (mul_coef),
    .done    (mul_done),
    .product (mul_product)
  );

  svf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && in_ready),
    .clear_in    (clear_state),
    .left_in     (left_sample),
    .right_in    (right_sample),
    .cfg         (cfg),
    .result_take (result_take),
    .stat        (stat),
    .left_res    (left_res),
    .right_res   (right_res),
    .mul_req     (mul_req),
    .mul_operand (mul_operand),
    .mul_coef    (mul_coef),
    .mul_done    (mul_done),
    .mul_product (mul_product)
  );

endmodule

>>> rtl/svf_checker.sv
module svf_checker import svf_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_out,
  input logic signed [SAMPLE_BITS-1:0] right_out
);

  a_busy_after_request: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready
  ) else $error("request accepted while a request is in progress");

  a_result_held: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(left_out) && $stable(right_out)
  ) else $error("stalled result changed or dropped");

  a_reset_state: assert property (
    @(posedge clk)
    $past(rst) |-> (!out_valid && in_ready)
  ) else $error("block not idle after reset");

  a_no_instant_result: assert property (
    @(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready)
  ) else $error("result appeared right after a request");

endmodule

bind stereo_state_variable_filter_top svf_checker u_svf_checker (.*);
